### src/i2cms_pkg.sv
// Shared types, command codes and sequence lengths of the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

	// Command codes carried in the opcode field.
	localparam logic [2:0] OP_START     = 3'd0;
	localparam logic [2:0] OP_STOP      = 3'd1;
	localparam logic [2:0] OP_WRITE     = 3'd2;
	localparam logic [2:0] OP_READ      = 3'd3;
	localparam logic [2:0] OP_SEND_ACK  = 3'd4;
	localparam logic [2:0] OP_READ_ACK  = 3'd5;

	// Write phases within one bit: drive data, raise SCL, lower SCL.
	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	// Step at which a read byte takes its last bit.
	localparam logic [4:0] READ_LAST_STEP = 5'd16;

	// One input tick.
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       tx_ack;
		logic       sda_in;
	} tick_t;

	// One result beat.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       rx_ack;
	} res_t;

	// Sequencer state held between ticks.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic [2:0] active_cmd;
		logic [4:0] step;
		logic [1:0] phase;
		logic       running;
		logic [7:0] shift_data;
		logic       ack_to_send;
		logic [7:0] received_byte;
		logic       received_ack;
	} state_t;

	localparam state_t STATE_RESET = '{
		scl_level:     1'b1,
		sda_level:     1'b1,
		active_cmd:    OP_START,
		step:          5'd0,
		phase:         PH_DATA,
		running:       1'b0,
		shift_data:    8'd0,
		ack_to_send:   1'b0,
		received_byte: 8'd0,
		received_ack:  1'b1
	};

	// Number of ticks each command takes.
	function automatic logic [4:0] seq_len(input logic [2:0] cmd);
		logic [4:0] len;
		case (cmd)
			OP_START:    len = 5'd4;
			OP_STOP:     len = 5'd3;
			OP_WRITE:    len = 5'd24;
			OP_READ:     len = 5'd17;
			OP_SEND_ACK: len = 5'd3;
			default:     len = 5'd3;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

### src/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: state register, result register and skid stage.
//
// Usage:
// - Input channel tick (tick_valid, tick_stall): each beat is one bus tick carrying an
//   optional command, the byte or acknowledge level to send and the sampled SDA level.
//   A tick performs exactly one pin assignment; start takes 4 ticks, stop 3, write
//   byte 24, read byte 17, each acknowledge 3. Commands that arrive while busy are
//   ignored, as are unknown opcodes.
// - Output channel res (res_valid, res_stall): one beat per tick with the SCL and SDA
//   drive levels, busy, done and the last received byte and acknowledge.
// - The result of an accepted tick goes into the result register, or into the skid stage
//   when the receiver stalls. One tick is accepted every cycle while tick_stall is low;
//   the only work per tick is the step logic between the state and result registers.
// - When the receiver stalls, one further result is caught in a skid stage, after
//   which tick_stall rises until the skid stage drains.
// - Reset puts the bus lines high (idle), clears the sequencer and empties both
//   result stages; the received acknowledge reads 1 after reset.
`default_nettype none

module i2c_master_bit_sequencer_unit (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              tick_valid,
	output logic                  tick_stall,
	input  var i2cms_pkg::tick_t  tick,
	output logic                  res_valid,
	input  var logic              res_stall,
	output i2cms_pkg::res_t       res
);

	i2cms_pkg::state_t st_q;
	i2cms_pkg::state_t st_next;
	i2cms_pkg::res_t   step_res;
	i2cms_pkg::res_t   res_q;
	i2cms_pkg::res_t   skid_q;
	logic              res_valid_q;
	logic              skid_valid_q;
	logic              accept;

	assign tick_stall = skid_valid_q;
	assign accept     = tick_valid && !tick_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	i2cms_step u_step (
		.st      (st_q),
		.tk      (tick),
		.st_next (st_next),
		.res     (step_res)
	);

	// Sequencer state advances on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= i2cms_pkg::STATE_RESET;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	// Result register and skid stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (!res_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (accept) begin
				res_q <= step_res;
			end
		end else if (accept) begin
			skid_q <= step_res;
		end
	end

	// A beat waits in the skid stage only behind a valid result.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid stage holds a beat while the result register is empty");

	// The last tick of a command never reports the sequencer as still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("done and busy reported together");

	// An unknown opcode on an idle sequencer starts nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !st_q.running && tick.cmd_valid &&
		 (tick.opcode == 3'd6 || tick.opcode == 3'd7)) |=> !st_q.running)
		else $error("unknown opcode started a sequence");

	// A tick that completes a command leaves the sequencer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step_res.done_res) |=> (!st_q.running && st_q.step == 5'd0))
		else $error("sequencer still running after its last tick");

endmodule

`default_nettype wire

### src/i2cms_step.sv
// Next-state and result logic for one tick of the I2C master bit sequencer.
`default_nettype none

module i2cms_step (
	input  var i2cms_pkg::state_t st,
	input  var i2cms_pkg::tick_t  tk,
	output i2cms_pkg::state_t     st_next,
	output i2cms_pkg::res_t       res
);

	i2cms_pkg::state_t cur;
	logic              start;
	logic              done;
	logic [7:0]        shifted;

	// Launch a command when idle and the opcode is a known one.
	always_comb begin
		start = !st.running && tk.cmd_valid && (tk.opcode inside {[i2cms_pkg::OP_START :
			i2cms_pkg::OP_READ_ACK]});
		cur = st;
		if (start) begin
			cur.active_cmd  = tk.opcode;
			cur.step        = 5'd0;
			cur.phase       = i2cms_pkg::PH_DATA;
			cur.running     = 1'b1;
			cur.shift_data  = (tk.opcode == i2cms_pkg::OP_WRITE) ? tk.tx_byte : 8'd0;
			cur.ack_to_send = tk.tx_ack;
		end
	end

	assign shifted = {cur.shift_data[6:0], tk.sda_in};

	// Perform one pin assignment and advance the step counter.
	always_comb begin
		st_next = cur;
		done    = 1'b0;
		if (cur.running) begin
			case (cur.active_cmd)
				i2cms_pkg::OP_START: begin
					case (cur.step)
						5'd0:    st_next.sda_level = 1'b1;
						5'd1:    st_next.scl_level = 1'b1;
						5'd2:    st_next.sda_level = 1'b0;
						default: st_next.scl_level = 1'b0;
					endcase
				end
				i2cms_pkg::OP_STOP: begin
					case (cur.step)
						5'd0:    st_next.sda_level = 1'b0;
						5'd1:    st_next.scl_level = 1'b1;
						default: st_next.sda_level = 1'b1;
					endcase
				end
				i2cms_pkg::OP_WRITE: begin
					// The byte shifts left so that the bit on the wire is always bit 7.
					case (cur.phase)
						i2cms_pkg::PH_DATA: st_next.sda_level = cur.shift_data[7];
						i2cms_pkg::PH_HIGH: st_next.scl_level = 1'b1;
						default: begin
							st_next.scl_level  = 1'b0;
							st_next.shift_data = {cur.shift_data[6:0], 1'b0};
						end
					endcase
				end
				i2cms_pkg::OP_READ: begin
					if (cur.step == 5'd0) begin
						st_next.sda_level = 1'b1;
					end else if (cur.step[0]) begin
						st_next.scl_level = 1'b1;
					end else begin
						st_next.shift_data = shifted;
						st_next.scl_level  = 1'b0;
						if (cur.step == i2cms_pkg::READ_LAST_STEP) begin
							st_next.received_byte = shifted;
						end
					end
				end
				i2cms_pkg::OP_SEND_ACK: begin
					case (cur.step)
						5'd0:    st_next.sda_level = cur.ack_to_send;
						5'd1:    st_next.scl_level = 1'b1;
						default: st_next.scl_level = 1'b0;
					endcase
				end
				default: begin
					case (cur.step)
						5'd0:    st_next.sda_level = 1'b1;
						5'd1:    st_next.scl_level = 1'b1;
						default: begin
							st_next.received_ack = tk.sda_in;
							st_next.scl_level    = 1'b0;
						end
					endcase
				end
			endcase

			// Write phase cycles through its three pin assignments.
			st_next.phase = (cur.phase == i2cms_pkg::PH_LOW) ? i2cms_pkg::PH_DATA :
				cur.phase + 2'd1;

			if ({1'b0, cur.step} + 6'd1 >= {1'b0, i2cms_pkg::seq_len(cur.active_cmd)}) begin
				st_next.running = 1'b0;
				st_next.step    = 5'd0;
				done            = 1'b1;
			end else begin
				st_next.step = cur.step + 5'd1;
			end
		end
	end

	// Result of this tick, taken from the updated state.
	always_comb begin
		res.scl_out  = st_next.scl_level;
		res.sda_out  = st_next.sda_level;
		res.busy_res = st_next.running;
		res.done_res = done;
		res.rx_byte  = st_next.received_byte;
		res.rx_ack   = st_next.received_ack;
	end

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the I2C master bit sequencer: random ticks, line-level prediction.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// One planned tick; drain_first holds it back until every result has come out.
	typedef struct {
		logic             drain_first;
		i2cms_pkg::tick_t t;
	} planned_tick_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             tick_valid = 1'b0;
	logic             tick_stall;
	i2cms_pkg::tick_t tick_data = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	i2cms_pkg::res_t  res_data;

	planned_tick_t   tick_plan[$];
	i2cms_pkg::res_t expected_lines[$];
	int              plan_total = 1;
	int              ticks_accepted = 0;
	int              mismatch_count = 0;

	// Predicted bus and sequencer state.
	logic       bus_scl = 1'b1;
	logic       bus_sda = 1'b1;
	logic [2:0] cur_op = i2cms_pkg::OP_START;
	logic [4:0] step_idx = 5'd0;
	logic       in_progress = 1'b0;
	logic [7:0] shreg = 8'h00;
	logic       ack_out = 1'b0;
	logic [7:0] last_byte = 8'h00;
	logic       last_ack = 1'b1;

	i2c_master_bit_sequencer_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res_data)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Generous limit; the slowest correct run needs well under a tenth of this.
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Number of ticks a command lasts; anything unknown occupies a single tick.
	function automatic int command_ticks(input logic [2:0] op);
		case (op)
			i2cms_pkg::OP_START:    return 4;
			i2cms_pkg::OP_STOP:     return 3;
			i2cms_pkg::OP_WRITE:    return 24;
			i2cms_pkg::OP_READ:     return 17;
			i2cms_pkg::OP_SEND_ACK: return 3;
			i2cms_pkg::OP_READ_ACK: return 3;
			default:                return 1;
		endcase
	endfunction

	// Advances the predicted sequencer by one tick and returns the line levels after it.
	function i2cms_pkg::res_t predict_bus_tick(input i2cms_pkg::tick_t t);
		i2cms_pkg::res_t r;
		logic            fin;
		logic [1:0]      wr_phase;
		logic [2:0]      bit_idx;
		fin = 1'b0;
		if (!in_progress && t.cmd_valid && t.opcode <= i2cms_pkg::OP_READ_ACK) begin
			cur_op = t.opcode;
			step_idx = 5'd0;
			in_progress = 1'b1;
			shreg = (t.opcode == i2cms_pkg::OP_WRITE) ? t.tx_byte : 8'h00;
			ack_out = t.tx_ack;
		end
		if (in_progress) begin
			case (cur_op)
				i2cms_pkg::OP_START: begin
					case (step_idx)
						5'd0: bus_sda = 1'b1;
						5'd1: bus_scl = 1'b1;
						5'd2: bus_sda = 1'b0;
						default: bus_scl = 1'b0;
					endcase
				end
				i2cms_pkg::OP_STOP: begin
					case (step_idx)
						5'd0: bus_sda = 1'b0;
						5'd1: bus_scl = 1'b1;
						default: bus_sda = 1'b1;
					endcase
				end
				i2cms_pkg::OP_WRITE: begin
					bit_idx = 3'(step_idx / 5'd3);
					wr_phase = 2'(step_idx % 5'd3);
					if (wr_phase == i2cms_pkg::PH_DATA)
						bus_sda = shreg[3'd7 - bit_idx];
					else if (wr_phase == i2cms_pkg::PH_HIGH)
						bus_scl = 1'b1;
					else
						bus_scl = 1'b0;
				end
				i2cms_pkg::OP_READ: begin
					// Release SDA first, then odd steps raise SCL and even steps sample.
					if (step_idx == 5'd0) begin
						bus_sda = 1'b1;
					end else if (step_idx[0]) begin
						bus_scl = 1'b1;
					end else begin
						shreg = {shreg[6:0], t.sda_in};
						bus_scl = 1'b0;
						if (step_idx == 5'd16)
							last_byte = shreg;
					end
				end
				i2cms_pkg::OP_SEND_ACK: begin
					case (step_idx)
						5'd0: bus_sda = ack_out;
						5'd1: bus_scl = 1'b1;
						default: bus_scl = 1'b0;
					endcase
				end
				default: begin
					case (step_idx)
						5'd0: bus_sda = 1'b1;
						5'd1: bus_scl = 1'b1;
						default: begin
							last_ack = t.sda_in;
							bus_scl = 1'b0;
						end
					endcase
				end
			endcase
			if (int'(step_idx) + 1 >= command_ticks(cur_op)) begin
				in_progress = 1'b0;
				fin = 1'b1;
				step_idx = 5'd0;
			end else begin
				step_idx = step_idx + 5'd1;
			end
		end
		r.scl_out = bus_scl;
		r.sda_out = bus_sda;
		r.busy_res = in_progress;
		r.done_res = fin;
		r.rx_byte = last_byte;
		r.rx_ack = last_ack;
		return r;
	endfunction

	// Idle rates: sender rarely and receiver often, then the reverse, then neither.
	function int sender_gap_pct();
		if (ticks_accepted < plan_total / 3)
			return 9;
		else if (ticks_accepted < 2 * plan_total / 3)
			return 82;
		return 0;
	endfunction

	function int receiver_stall_pct();
		if (ticks_accepted < plan_total / 3)
			return 82;
		else if (ticks_accepted < 2 * plan_total / 3)
			return 9;
		return 0;
	endfunction

	task report_mismatch(input string what, input int want, input int got);
		$display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	task check_field(input string what, input int want, input int got);
		if (want != got)
			report_mismatch(what, want, got);
	endtask

	// Queues one command: its opening tick, then the rest of its run. During the run the
	// command fields carry noise, which the sequencer must ignore while busy.
	task add_command(input logic [2:0] op, input logic [7:0] data, input logic ack,
			input logic [31:0] sda_bits, input int noise_pct, input logic drain);
		planned_tick_t p;
		for (int i = 0; i < command_ticks(op); i++) begin
			p.drain_first = drain && (i == 0);
			p.t.cmd_valid = (i == 0) ? 1'b1 : ($urandom_range(99) < noise_pct);
			p.t.opcode = (i == 0) ? op : 3'($urandom_range(7));
			p.t.tx_byte = (i == 0) ? data : 8'($urandom);
			p.t.tx_ack = (i == 0) ? ack : 1'($urandom_range(1));
			p.t.sda_in = sda_bits[i];
			tick_plan.push_back(p);
		end
	endtask

	task add_idle(input int count);
		planned_tick_t p;
		for (int i = 0; i < count; i++) begin
			p.drain_first = 1'b0;
			p.t = i2cms_pkg::tick_t'(14'($urandom));
			p.t.cmd_valid = 1'b0;
			tick_plan.push_back(p);
		end
	endtask

	// Driver: presents the next planned tick and predicts each accepted beat.
	always @(posedge clk or negedge arst_n) begin : drive_ticks
		logic took;
		if (!arst_n) begin
			tick_valid <= 1'b0;
			tick_data <= '0;
		end else begin
			took = tick_valid && !tick_stall;
			if (took) begin
				expected_lines.push_back(predict_bus_tick(tick_data));
				ticks_accepted <= ticks_accepted + 1;
			end
			if (!tick_valid || took) begin
				if (tick_plan.size() != 0
						&& !(tick_plan[0].drain_first && expected_lines.size() != 0)
						&& $urandom_range(99) >= sender_gap_pct()) begin
					tick_data <= tick_plan[0].t;
					tick_valid <= 1'b1;
					void'(tick_plan.pop_front());
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : watch_results
		i2cms_pkg::res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_lines.size() == 0) begin
					report_mismatch("result beat with nothing predicted", 0, 1);
				end else begin
					want = expected_lines.pop_front();
					check_field("scl_out", want.scl_out, res_data.scl_out);
					check_field("sda_out", want.sda_out, res_data.sda_out);
					check_field("busy_res", want.busy_res, res_data.busy_res);
					check_field("done_res", want.done_res, res_data.done_res);
					check_field("rx_byte", want.rx_byte, res_data.rx_byte);
					check_field("rx_ack", want.rx_ack, res_data.rx_ack);
				end
			end
			res_stall <= ($urandom_range(99) < receiver_stall_pct());
		end
	end

	// Stimulus plan and end of run.
	initial begin : run_sequence
		int         r;
		int         directed_len;
		logic       drain_done;
		logic [2:0] op;
		drain_done = 1'b0;

		// Directed: every command, extreme bytes, both acknowledge levels, busy and
		// unknown commands, and a read with each sampled level.
		add_idle(2);
		add_command(i2cms_pkg::OP_START, 8'h00, 1'b0, $urandom, 0, 1'b0);
		add_command(i2cms_pkg::OP_WRITE, 8'hFF, 1'b1, $urandom, 0, 1'b0);
		add_command(i2cms_pkg::OP_WRITE, 8'h00, 1'b0, $urandom, 0, 1'b0);
		add_command(i2cms_pkg::OP_WRITE, 8'hA5, 1'b0, $urandom, 100, 1'b0);
		add_command(i2cms_pkg::OP_READ_ACK, 8'h00, 1'b0, 32'h0000_0000, 0, 1'b0);
		add_command(i2cms_pkg::OP_READ_ACK, 8'hFF, 1'b1, 32'hFFFF_FFFF, 0, 1'b0);
		add_command(i2cms_pkg::OP_READ, 8'h00, 1'b0, 32'hFFFF_FFFF, 0, 1'b0);
		add_command(i2cms_pkg::OP_READ, 8'hFF, 1'b1, 32'h0000_0000, 100, 1'b0);
		add_command(i2cms_pkg::OP_READ, 8'h3C, 1'b0, 32'h0001_5540, 0, 1'b0);
		add_command(i2cms_pkg::OP_SEND_ACK, 8'h00, 1'b0, $urandom, 0, 1'b0);
		add_command(i2cms_pkg::OP_SEND_ACK, 8'hFF, 1'b1, $urandom, 0, 1'b0);
		add_command(3'd6, 8'h5A, 1'b1, $urandom, 0, 1'b0);
		add_command(3'd7, 8'hC3, 1'b0, $urandom, 0, 1'b0);
		add_command(i2cms_pkg::OP_STOP, 8'h00, 1'b1, $urandom, 0, 1'b0);
		add_idle(3);
		add_command(i2cms_pkg::OP_STOP, 8'hFF, 1'b0, $urandom, 0, 1'b0);
		directed_len = tick_plan.size();

		// Random: mostly whole commands with random content, some noise in between.
		while (tick_plan.size() < 900) begin
			r = $urandom_range(99);
			if (r < 6) begin
				op = 3'($urandom_range(7, 6));
				add_command(op, 8'($urandom), 1'($urandom), $urandom, 0, 1'b0);
			end else if (r < 14) begin
				add_idle($urandom_range(3, 1));
			end else begin
				op = 3'($urandom_range(5));
				add_command(op, 8'($urandom), 1'($urandom), $urandom, 10,
					!drain_done && tick_plan.size() > 450);
				if (tick_plan.size() > 450)
					drain_done = 1'b1;
			end
		end
		plan_total = tick_plan.size();
		$display("planned %0d directed and %0d random ticks", directed_len,
			plan_total - directed_len);

		do
			@(posedge clk);
		while (!arst_n || tick_plan.size() != 0 || tick_valid || expected_lines.size() != 0);
		repeat (10) @(posedge clk);

		if (expected_lines.size() != 0)
			report_mismatch("predicted beats never seen", 0, expected_lines.size());
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### i2c_master_bit_sequencer_unit.f
src/i2cms_pkg.sv
src/i2cms_step.sv
src/i2c_master_bit_sequencer_unit.sv
bench/testbench.sv
